// ===== src/accel_tap_detector_macros.svh =====
// Assertion macros shared by the tap detector modules.
// Expects aclk and aresetn in the scope of every use.
`ifndef ACCEL_TAP_DETECTOR_MACROS_SVH
`define ACCEL_TAP_DETECTOR_MACROS_SVH

// property checked on every clock edge outside reset
`define ATD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// condition that must never be seen outside reset
`define ATD_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

// ===== src/atd_pkg.sv =====
// Types, constants and helpers of the accelerometer tap detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package atd_pkg;

    localparam int NUM_AXES = 3;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_STABLE_X       = 3'd0,
        REG_STABLE_Y       = 3'd1,
        REG_STABLE_Z       = 3'd2,
        REG_ACTIVE_X       = 3'd3,
        REG_ACTIVE_Y       = 3'd4,
        REG_ACTIVE_Z       = 3'd5,
        REG_ABSOLUTE       = 3'd6,
        REG_FIRST_TAP_BONUS = 3'd7
    } atd_reg_t;

    localparam logic [7:0] RST_STABLE_LIMIT   = 8'd30;
    localparam logic [7:0] RST_ACTIVE_LIMIT   = 8'd40;
    localparam logic [7:0] RST_ABSOLUTE_LIMIT = 8'd120;
    localparam logic [7:0] RST_FIRST_TAP_BONUS = 8'd10;

    localparam logic [8:0] MAG_SUM_LIMIT   = 9'd253;
    localparam logic [8:0] SINCE_SAT       = 9'd300;
    localparam logic [8:0] FIRST_TAP_AFTER = 9'd290;
    localparam logic [7:0] QUIET_DIFF      = 8'd5;

    localparam logic [3:0] HOLDOFF_VIOLENT    = 4'd10;
    localparam logic [3:0] HOLDOFF_STABLE_TAP = 4'd7;
    localparam logic [3:0] HOLDOFF_MULTI_TAP  = 4'd5;

    localparam logic [3:0] STABLE_MAX      = 4'd15;
    localparam logic [3:0] STABLE_STICK    = 4'd14;
    localparam logic [3:0] STABLE_LIMIT_SEL = 4'd5;
    localparam logic [3:0] STABLE_TAP_SEL  = 4'd10;
    localparam logic [3:0] STABLE_DROP     = 4'd4;

    localparam logic [2:0] ALL_AXES = 3'b111;

    // one classified sample on its way from front to back
    typedef struct packed {
        logic [NUM_AXES-1:0][7:0] diff;
        logic                     stable;
        logic                     hold_load;
    } atd_item_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][7:0] stable_limit;
        logic [NUM_AXES-1:0][7:0] active_limit;
        logic [7:0]               absolute_limit;
        logic [7:0]               first_tap_bonus;
    } atd_cfg_t;

    // magnitude of an 8-bit two's complement value; -128 gives 128
    function automatic logic [7:0] mag8(input logic [7:0] v);
        return v[7] ? (~v + 8'd1) : v;
    endfunction

endpackage

// ===== src/accel_tap_detector.sv =====
// A sample accepted from s_tdata is written into the queue, then popped by the back end,
// which updates its state and loads the result register that drives m_tvalid. Throughput
// is one sample per cycle while m_tready holds high. A four-entry queue lets front and
// back stall apart.
// Reset (aresetn low, synchronous) restores the limit registers to their defaults,
// clears all detector state and empties the queue; the block is ready the next cycle.
`timescale 1ns / 1ps

module accel_tap_detector #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // sample_x, sample_y, sample_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // tap_detected, zero padding
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import atd_pkg::*;

    atd_cfg_t  cfg_reg, cfg_next;
    atd_item_t front_item, back_item;
    logic      q_push, q_pop, q_full, q_empty;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (atd_reg_t'(cfg_addr))
                REG_STABLE_X:        cfg_next.stable_limit[0] = cfg_wdata;
                REG_STABLE_Y:        cfg_next.stable_limit[1] = cfg_wdata;
                REG_STABLE_Z:        cfg_next.stable_limit[2] = cfg_wdata;
                REG_ACTIVE_X:        cfg_next.active_limit[0] = cfg_wdata;
                REG_ACTIVE_Y:        cfg_next.active_limit[1] = cfg_wdata;
                REG_ACTIVE_Z:        cfg_next.active_limit[2] = cfg_wdata;
                REG_ABSOLUTE:        cfg_next.absolute_limit  = cfg_wdata;
                REG_FIRST_TAP_BONUS: cfg_next.first_tap_bonus = cfg_wdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stable_limit    <= {NUM_AXES{RST_STABLE_LIMIT}};
            cfg_reg.active_limit    <= {NUM_AXES{RST_ACTIVE_LIMIT}};
            cfg_reg.absolute_limit  <= RST_ABSOLUTE_LIMIT;
            cfg_reg.first_tap_bonus <= RST_FIRST_TAP_BONUS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    atd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (front_item)
    );

    atd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_item (front_item),
        .full    (q_full),
        .pop     (q_pop),
        .rd_item (back_item),
        .empty   (q_empty)
    );

    atd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_item   (back_item),
        .q_pop    (q_pop),
        .cfg      (cfg_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== src/atd_front.sv =====
// Front end: accepts samples, forms wrapped differences and classifies them.
// Depends on atd_pkg; feeds atd_queue.
`timescale 1ns / 1ps

module atd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,   // sample_x, sample_y, sample_z
    input  logic               q_full,
    output logic               q_push,
    output atd_pkg::atd_item_t q_item
);
    import atd_pkg::*;

    logic [NUM_AXES-1:0][7:0] prev_sample_reg, prev_sample_next;
    logic [NUM_AXES-1:0][7:0] prev_mag_reg, prev_mag_next;
    logic [NUM_AXES-1:0][7:0] mag;
    logic [NUM_AXES-1:0][7:0] adiff;
    logic [NUM_AXES-1:0][8:0] mag_sum;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_item.stable    = 1'b1;
        q_item.hold_load = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            mag[a]         = mag8(s_tdata[8*a +: 8]);
            q_item.diff[a] = s_tdata[8*a +: 8] - prev_sample_reg[a];
            adiff[a]       = mag8(q_item.diff[a]);
            mag_sum[a]     = {1'b0, prev_mag_reg[a]} + {1'b0, mag[a]};
            // near full scale on both sides of a step
            if (mag_sum[a] > MAG_SUM_LIMIT) begin
                q_item.hold_load = 1'b1;
            end
            if (adiff[a] >= QUIET_DIFF) begin
                q_item.stable = 1'b0;
            end
        end
        prev_sample_next = prev_sample_reg;
        prev_mag_next    = prev_mag_reg;
        if (q_push) begin
            prev_sample_next = s_tdata;
            prev_mag_next    = mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sample_reg <= '0;
            prev_mag_reg    <= '0;
        end else begin
            prev_sample_reg <= prev_sample_next;
            prev_mag_reg    <= prev_mag_next;
        end
    end

endmodule

// ===== src/atd_queue.sv =====
// Short queue of classified samples between front and back end.
// Depends on atd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "accel_tap_detector_macros.svh"

module atd_queue #(
    parameter int DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  atd_pkg::atd_item_t wr_item,
    output logic               full,
    input  logic               pop,
    output atd_pkg::atd_item_t rd_item,
    output logic               empty
);
    import atd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    atd_item_t         slot_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    `ATD_NEVER(a_count_range, count_reg > CW'(DEPTH), "queue count beyond depth")
    `ATD_ASSERT(a_push_grows, do_push && !do_pop |=> count_reg == $past(count_reg) + CW'(1), "queue count did not grow on push")
    `ATD_ASSERT(a_ptr_gap, empty |-> wr_ptr_reg == rd_ptr_reg, "queue pointers apart while empty")

endmodule

// ===== src/atd_back.sv =====
// Back end: tap state machine proper (counters, flags, history) and result register.
// Depends on atd_pkg and the assertion macro header; fed by atd_queue.
`timescale 1ns / 1ps
`include "accel_tap_detector_macros.svh"

module atd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  atd_pkg::atd_item_t q_item,
    output logic               q_pop,
    input  atd_pkg::atd_cfg_t  cfg,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata    // tap_detected, zero padding
);
    import atd_pkg::*;

    logic [NUM_AXES-1:0][7:0] hist0_reg, hist0_next;
    logic [NUM_AXES-1:0][7:0] hist1_reg, hist1_next;
    logic [3:0]               stable_count_reg, stable_count_next;
    logic [3:0]               holdoff_reg, holdoff_next;
    logic [8:0]               since_reg, since_next;
    logic [6:0]               flags_reg, flags_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic                     tap_reg, tap_next;

    logic [8:0]               since_inc;
    logic                     first;
    logic [3:0]               hold_mid;
    logic [NUM_AXES-1:0][7:0] adiff, a1, a2, gap, lim;
    logic [7:0]               alim;
    logic [NUM_AXES-1:0]      hit, violent;
    logic [6:0]               f;

    assign q_pop    = !q_empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, tap_reg};

    // per-axis tests, independent of one another
    always_comb begin
        since_inc = (since_reg < SINCE_SAT) ? since_reg + 9'd1 : since_reg;
        first     = since_inc > FIRST_TAP_AFTER;
        hold_mid  = q_item.hold_load ? HOLDOFF_VIOLENT : holdoff_reg;

        if (q_item.stable) begin
            stable_count_next = (stable_count_reg >= STABLE_STICK) ? STABLE_MAX
                                                                   : stable_count_reg + 4'd1;
        end else begin
            stable_count_next = (stable_count_reg < STABLE_DROP) ? 4'd0
                                                                 : stable_count_reg - 4'd1;
        end

        alim = first ? cfg.absolute_limit + cfg.first_tap_bonus : cfg.absolute_limit;
        for (int a = 0; a < NUM_AXES; a++) begin
            adiff[a] = mag8(q_item.diff[a]);
            a1[a]    = mag8(hist0_reg[a]);
            a2[a]    = mag8(hist1_reg[a]);
            gap[a]   = (adiff[a] > a1[a]) ? adiff[a] - a1[a] : a1[a] - adiff[a];
            lim[a]   = (stable_count_next > STABLE_LIMIT_SEL) ? cfg.stable_limit[a]
                                                              : cfg.active_limit[a];
            if (first) begin
                lim[a] = lim[a] + cfg.first_tap_bonus;
            end
            // sign reversal, similar size, peak over limit, sharp shape
            hit[a] = (q_item.diff[a][7] != hist0_reg[a][7])
                  && (gap[a] < {1'b0, a1[a][7:1]})
                  && (a1[a] > lim[a])
                  && ((hist0_reg[a][7] != hist1_reg[a][7]) || ({2'b0, a1[a][7:2]} > a2[a]));
            violent[a] = a1[a] > alim;
        end
    end

    always_comb begin
        hist0_next    = hist0_reg;
        hist1_next    = hist1_reg;
        holdoff_next  = holdoff_reg;
        since_next    = since_reg;
        flags_next    = flags_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        tap_next      = tap_reg;
        f             = flags_reg;

        if (q_pop) begin
            m_tvalid_next = 1'b1;
            tap_next      = 1'b0;
            since_next    = since_inc;
            hist1_next    = hist0_reg;
            hist0_next    = q_item.diff;

            if (q_item.stable) begin
                if (stable_count_reg >= STABLE_STICK) begin
                    flags_next = '0;
                end
                holdoff_next = (hold_mid != 4'd0) ? hold_mid - 4'd1 : hold_mid;
            end else if (hold_mid != 4'd0) begin
                holdoff_next = hold_mid - 4'd1;
            end else begin
                holdoff_next = hold_mid;
                // axes in order: a hit with another axis flag set or a violent peak fills all
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (hit[a]) begin
                        f[a] = 1'b1;
                        if (violent[a] || ((f[2:0] & ~(3'b001 << a)) != 3'b000)) begin
                            f = {4'b0000, ALL_AXES};
                        end
                    end
                end

                if (stable_count_next > STABLE_TAP_SEL) begin
                    if (f != '0) begin
                        tap_next     = 1'b1;
                        holdoff_next = HOLDOFF_STABLE_TAP;
                        flags_next   = '0;
                        since_next   = '0;
                    end else begin
                        flags_next = f;
                    end
                end else if (f[2:0] == ALL_AXES) begin
                    tap_next     = 1'b1;
                    holdoff_next = HOLDOFF_MULTI_TAP;
                    flags_next   = '0;
                    since_next   = '0;
                end else begin
                    // pending clears drop their hit, hits become pending
                    flags_next[2:0] = f[2:0] & ~f[6:4];
                    flags_next[3]   = f[3] | (|f[6:4]);
                    flags_next[6:4] = f[6:4] | flags_next[2:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist0_reg        <= '0;
            hist1_reg        <= '0;
            stable_count_reg <= '0;
            holdoff_reg      <= '0;
            since_reg        <= '0;
            flags_reg        <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            hist0_reg        <= hist0_next;
            hist1_reg        <= hist1_next;
            stable_count_reg <= q_pop ? stable_count_next : stable_count_reg;
            holdoff_reg      <= holdoff_next;
            since_reg        <= since_next;
            flags_reg        <= flags_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tap_reg <= tap_next;
    end

    `ATD_NEVER(a_holdoff_range, holdoff_reg > HOLDOFF_VIOLENT, "hold-off beyond its load value")
    `ATD_NEVER(a_since_range, since_reg > SINCE_SAT, "since-tap count beyond saturation")
    `ATD_ASSERT(a_tap_clears, q_pop && tap_next |=> flags_reg == '0 && since_reg == '0 && holdoff_reg != 4'd0, "tap left flags or counters behind")
    `ATD_ASSERT(a_result_held, m_tvalid_reg && !m_tready |=> m_tvalid_reg && tap_reg == $past(tap_reg), "waiting result lost")

endmodule
